// ===== sv/word_length_histogram_macros.svh =====
// Assertion macros for the word length histogram block.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef WORD_LENGTH_HISTOGRAM_MACROS_SVH
`define WORD_LENGTH_HISTOGRAM_MACROS_SVH

`ifndef ASSERT_OFF
`define WLH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wlh assertion failed");
`define WLH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wlh assertion failed");
`else
`define WLH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WLH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/wlh_pkg.sv =====
package wlh_pkg;

    localparam int NUM_BINS   = 64;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_W     = $clog2(NUM_BINS);
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 6;
    localparam int LONG_W     = 6;

    localparam logic [CHAR_W-1:0] UPPER_LO = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_HI = 8'd90;
    localparam logic [CHAR_W-1:0] LOWER_LO = 8'd97;
    localparam logic [CHAR_W-1:0] LOWER_HI = 8'd122;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [ADDR_W-1:0]     t_addr;

    localparam t_count COUNT_MAX = '1;
    localparam t_addr  LAST_BIN  = t_addr'(NUM_BINS - 1);

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_READ = 2'd1,
        OP_END  = 2'd2
    } t_op;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_req;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_count data;
    } t_wr_req;

    function automatic logic is_letter(logic [CHAR_W-1:0] c);
        return ((c >= UPPER_LO) && (c <= UPPER_HI)) ||
               ((c >= LOWER_LO) && (c <= LOWER_HI));
    endfunction

endpackage

// ===== sv/wlh_hist_store.sv =====
module wlh_hist_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wlh_pkg::t_rd_req i_rd,
    input  wlh_pkg::t_wr_req i_wr,
    output wlh_pkg::t_count  o_count
);

    wlh_pkg::t_count mem [wlh_pkg::NUM_BINS];

    logic [wlh_pkg::NUM_BINS-1:0] r_valid;
    wlh_pkg::t_count              r_rd_data;
    wlh_pkg::t_addr               r_rd_addr;
    wlh_pkg::t_wr_req             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
            r_rd_addr <= i_rd.addr;
        end
    end

    // valid bits stand in for clearing the array; r_fwd is the last write,
    // which may land on the same edge as the read and be missed by it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fwd   <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_fwd              <= i_wr;
        end
    end

    always_comb begin
        if (r_fwd.en && (r_fwd.addr == r_rd_addr)) begin
            o_count = r_fwd.data;
        end else if (r_valid[r_rd_addr]) begin
            o_count = r_rd_data;
        end else begin
            o_count = '0;
        end
    end

endmodule

// ===== sv/word_length_histogram.sv =====
// A request goes through the stage 1 registers, then the output registers.
// One request per cycle unless the output stalls; the bin read-modify-write
// forwards the previous write, so consecutive words in the same bin do not
// stall. Reset (synchronous, active low) clears the run state, the maxima and
// one valid bit per bin at once; no clearing pass, requests are taken right away.
`include "word_length_histogram_macros.svh"

module word_length_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // char_code[7:0], bin_index[13:8], zero pad
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // bin_count[15:0], longest_run[21:16],
                                       // tallest_bin[37:22], zero pad
    output logic        m_axis_tuser   // word_done
);

    logic                              accept_in;
    logic                              out_free;
    logic                              s1_move;
    wlh_pkg::t_cmd                     cmd;
    logic [wlh_pkg::CHAR_W-1:0]        ch;
    logic [wlh_pkg::IDX_W-1:0]         idx;
    logic                              letter;
    logic                              word_end;

    logic                              r_inside, n_inside;
    wlh_pkg::t_addr                    r_run, n_run;
    wlh_pkg::t_addr                    r_longest, n_longest;
    wlh_pkg::t_count                   r_tallest, n_tallest;

    logic                              r_s1_valid;
    wlh_pkg::t_op                      r_s1_op;
    logic                              r_s1_in_range;
    wlh_pkg::t_addr                    r_s1_addr;
    wlh_pkg::t_addr                    r_s1_longest;

    logic                              r_out_valid;
    wlh_pkg::t_count                   r_out_count;
    logic                              r_out_done;
    wlh_pkg::t_addr                    r_out_longest;
    wlh_pkg::t_count                   r_out_tallest;

    wlh_pkg::t_rd_req                  rd_req;
    wlh_pkg::t_wr_req                  wr_req;
    wlh_pkg::t_count                   stored;
    wlh_pkg::t_count                   bumped;
    wlh_pkg::t_count                   s1_count;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept_in     = s_axis_tvalid && s_axis_tready;

    assign cmd      = wlh_pkg::t_cmd'(s_axis_tuser);
    assign ch       = s_axis_tdata[7:0];
    assign idx      = s_axis_tdata[13:8];
    assign letter   = wlh_pkg::is_letter(ch);
    assign word_end = (cmd == wlh_pkg::CMD_CHAR) && !letter && r_inside;

    // run tracking needs no memory and is settled at accept
    always_comb begin
        n_run     = r_run;
        n_inside  = r_inside;
        n_longest = r_longest;
        if (accept_in && (cmd == wlh_pkg::CMD_CHAR)) begin
            if (letter) begin
                if (r_run < wlh_pkg::LAST_BIN) begin
                    n_run = r_run + 1'b1;
                end
                n_inside = 1'b1;
                if (n_run > r_longest) begin
                    n_longest = n_run;
                end
            end else if (r_inside) begin
                n_run    = '0;
                n_inside = 1'b0;
            end
        end
    end

    always_comb begin
        rd_req.en   = accept_in && ((cmd == wlh_pkg::CMD_READ) || word_end);
        rd_req.addr = (cmd == wlh_pkg::CMD_READ) ? wlh_pkg::t_addr'(idx) : r_run;
    end

    wlh_hist_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_req),
        .i_wr    (wr_req),
        .o_count (stored)
    );

    assign bumped = (stored == wlh_pkg::COUNT_MAX) ? stored : stored + 1'b1;

    always_comb begin
        wr_req.en   = s1_move && (r_s1_op == wlh_pkg::OP_END);
        wr_req.addr = r_s1_addr;
        wr_req.data = bumped;
        n_tallest   = r_tallest;
        case (r_s1_op)
            wlh_pkg::OP_END: begin
                s1_count = bumped;
                if (bumped > r_tallest) begin
                    n_tallest = bumped;
                end
            end
            wlh_pkg::OP_READ: s1_count = r_s1_in_range ? stored : '0;
            default:          s1_count = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_inside    <= 1'b0;
            r_longest   <= '0;
            r_tallest   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run     <= n_run;
            r_inside  <= n_inside;
            r_longest <= n_longest;
            if (s1_move) begin
                r_tallest <= n_tallest;
            end
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            if (cmd == wlh_pkg::CMD_READ) begin
                r_s1_op <= wlh_pkg::OP_READ;
            end else if (word_end) begin
                r_s1_op <= wlh_pkg::OP_END;
            end else begin
                r_s1_op <= wlh_pkg::OP_NONE;
            end
            r_s1_in_range <= (32'(idx) < wlh_pkg::NUM_BINS);
            r_s1_addr     <= rd_req.addr;
            r_s1_longest  <= n_longest;
        end
        if (s1_move) begin
            r_out_count   <= s1_count;
            r_out_done    <= (r_s1_op == wlh_pkg::OP_END);
            r_out_longest <= r_s1_longest;
            r_out_tallest <= n_tallest;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_done;
    assign m_axis_tdata  = {2'b00, 16'(r_out_tallest),
                            wlh_pkg::LONG_W'(r_out_longest), 16'(r_out_count)};

    `WLH_ASSERT_IMP(a_run_cleared, i_clk, i_rst_n, !r_inside, r_run == '0)
    `WLH_ASSERT_IMP(a_done_nonzero, i_clk, i_rst_n, r_out_valid && r_out_done,
                    r_out_count != '0)
    `WLH_ASSERT_IMP(a_tallest_covers, i_clk, i_rst_n, r_out_valid && r_out_done,
                    r_out_tallest >= r_out_count)
    `WLH_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n,
                    r_s1_valid && r_out_valid && !m_axis_tready, !s_axis_tready)
    `WLH_ASSERT_NXT(a_run_saturates, i_clk, i_rst_n, r_run == wlh_pkg::LAST_BIN,
                    r_run == wlh_pkg::LAST_BIN || r_run == '0)

endmodule

// ===== tb/sv/word_length_histogram_checker.sv =====
module word_length_histogram_checker
    import wlh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,     // char_code[7:0], bin_index[13:8], zero pad
    input  logic        i_req_user,     // command
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [39:0] i_rsp_data,     // bin_count[15:0], longest_run[21:16],
                                        // tallest_bin[37:22], zero pad
    input  logic        i_rsp_user,     // word_done
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_binned
);

    typedef struct packed {
        t_count            count;
        logic              done;
        logic [LONG_W-1:0] longest;
        t_count            tallest;
    } t_hist_result;

    // predictor state
    t_count            word_counts [NUM_BINS];
    t_addr             run_len;
    logic              in_word;
    logic [LONG_W-1:0] longest_len;
    t_count            tallest_count;

    t_hist_result      pending_results [$];
    int                accepted_n;
    int                checked_n;
    int                errors;
    int                words_binned;

    assign o_fail_count   = errors;
    assign o_pending      = accepted_n - checked_n;
    assign o_words_binned = words_binned;

    function automatic logic is_alpha(logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] folded;
        // bit 5 is the only difference between the two letter ranges
        folded = ch | 8'h20;
        return (folded >= LOWER_LO) && (folded <= LOWER_HI);
    endfunction

    function automatic t_hist_result predict_histogram_step(t_cmd cmd,
                                                            logic [CHAR_W-1:0] ch,
                                                            logic [IDX_W-1:0] idx);
        t_hist_result r;
        t_addr        slot;
        r = '0;
        if (cmd == CMD_READ) begin
            if (int'(idx) < NUM_BINS) begin
                r.count = word_counts[idx];
            end
        end else if (is_alpha(ch)) begin
            if (run_len < LAST_BIN) begin
                run_len = run_len + 1'b1;
            end
            if (run_len > longest_len) begin
                longest_len = run_len;
            end
            in_word = 1'b1;
        end else if (in_word) begin
            slot = run_len;
            if (word_counts[slot] != COUNT_MAX) begin
                word_counts[slot] = word_counts[slot] + 1'b1;
            end
            r.count = word_counts[slot];
            if (r.count > tallest_count) begin
                tallest_count = r.count;
            end
            run_len = '0;
            in_word = 1'b0;
            r.done = 1'b1;
            words_binned++;
        end
        r.longest = longest_len;
        r.tallest = tallest_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_hist_result want;
        t_hist_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                word_counts[i] = '0;
            end
            run_len       = '0;
            in_word       = 1'b0;
            longest_len   = '0;
            tallest_count = '0;
            pending_results.delete();
            accepted_n   <= 0;
            checked_n    <= 0;
        end else begin
            // a response at this edge always belongs to an earlier request
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    got.count   = i_rsp_data[15:0];
                    got.longest = i_rsp_data[21:16];
                    got.tallest = i_rsp_data[37:22];
                    got.done    = i_rsp_user;
                    if (got.count !== want.count) begin
                        report_mismatch($sformatf("response %0d bin_count exp %0d got %0d",
                                                  checked_n, want.count, got.count));
                    end
                    if (got.done !== want.done) begin
                        report_mismatch($sformatf("response %0d word_done exp %0d got %0d",
                                                  checked_n, want.done, got.done));
                    end
                    if (got.longest !== want.longest) begin
                        report_mismatch($sformatf("response %0d longest_run exp %0d got %0d",
                                                  checked_n, want.longest, got.longest));
                    end
                    if (got.tallest !== want.tallest) begin
                        report_mismatch($sformatf("response %0d tallest_bin exp %0d got %0d",
                                                  checked_n, want.tallest, got.tallest));
                    end
                    checked_n <= checked_n + 1;
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_results.push_back(predict_histogram_step(t_cmd'(i_req_user),
                                                                 i_req_data[7:0],
                                                                 i_req_data[13:8]));
                accepted_n <= accepted_n + 1;
            end
        end
    end

    initial begin
        errors       = 0;
        words_binned = 0;
    end

endmodule

// ===== tb/sv/word_length_histogram_test.sv =====
module word_length_histogram_test;
    import wlh_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 560;
    localparam int DRAIN_CYCLES  = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // char_code[7:0], bin_index[13:8], zero pad
    logic        s_tuser = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // bin_count[15:0], longest_run[21:16], tallest_bin[37:22]
    logic        m_tuser;        // word_done

    int fail_count;
    int pending;
    int words_binned;
    int cycles = 0;
    int sent_items = 0;
    int sent_reads = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    word_length_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    word_length_histogram_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_tvalid),
        .i_req_ready    (s_tready),
        .i_req_data     (s_tdata),
        .i_req_user     (s_tuser),
        .i_rsp_valid    (m_tvalid),
        .i_rsp_ready    (m_tready),
        .i_rsp_data     (m_tdata),
        .i_rsp_user     (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_words_binned (words_binned)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1)) begin
            return UPPER_LO + 8'($urandom_range(25));
        end
        return LOWER_LO + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] random_separator();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        while (((ch | 8'h20) >= LOWER_LO) && ((ch | 8'h20) <= LOWER_HI)) begin
            ch = 8'($urandom_range(255));
        end
        return ch;
    endfunction

    task automatic send_req(t_cmd cmd, logic [7:0] ch, logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, ch};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        sent_items++;
        if (cmd == CMD_READ) begin
            sent_reads++;
        end
    endtask

    task automatic send_word(int len);
        for (int i = 0; i < len; i++) begin
            send_req(CMD_CHAR, random_letter(), 6'($urandom_range(63)));
        end
    endtask

    task automatic send_read(logic [5:0] idx);
        send_req(CMD_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // mostly words with random letters; some reads, stray bytes and reads mid-word
    task automatic random_phase(int items, int idle_pct, int stall_pct);
        int stop_at;
        int roll;
        stop_at = sent_items + items;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (sent_items < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                send_word(($urandom_range(99) < 4) ? $urandom_range(58, 80)
                                                   : $urandom_range(1, 12));
                repeat ($urandom_range(1, 2)) send_req(CMD_CHAR, random_separator(), '0);
            end else if (roll < 80) begin
                send_read(6'($urandom_range(63)));
            end else if (roll < 90) begin
                send_req(CMD_CHAR, 8'($urandom_range(255)), 6'($urandom_range(63)));
            end else begin
                send_word($urandom_range(1, 6));
                send_read(6'($urandom_range(63)));
                send_word($urandom_range(1, 6));
                send_req(CMD_CHAR, random_separator(), 6'($urandom_range(63)));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // letter range edges, same-bin back to back, reads at both index ends
        send_read(6'd0);
        send_read(6'h3F);
        send_req(CMD_CHAR, 8'h00, 6'h00);
        send_req(CMD_CHAR, 8'hFF, 6'h3F);
        send_req(CMD_CHAR, 8'd64, 6'h15);
        send_req(CMD_CHAR, 8'd65, 6'h2A);
        send_req(CMD_CHAR, 8'd90, 6'h00);
        send_req(CMD_CHAR, 8'd91, 6'h00);
        send_req(CMD_CHAR, 8'd96, 6'h00);
        send_req(CMD_CHAR, 8'd97, 6'h00);
        send_req(CMD_CHAR, 8'd122, 6'h00);
        send_req(CMD_CHAR, 8'd123, 6'h00);
        send_req(CMD_CHAR, 8'd122, 6'h00);
        send_req(CMD_CHAR, 8'hFF, 6'h00);
        send_req(CMD_CHAR, 8'd97, 6'h00);
        send_req(CMD_CHAR, 8'h20, 6'h00);
        send_req(CMD_CHAR, 8'h80, 6'h00);
        send_read(6'd1);
        send_read(6'd2);
        send_read(6'h2A);
        send_read(6'h15);
        wait_drained();

        random_phase(RANDOM_ITEMS / 4, 0, 0);
        random_phase(RANDOM_ITEMS / 4, 55, 0);
        random_phase(RANDOM_ITEMS / 4, 0, 55);
        random_phase(RANDOM_ITEMS / 4, 29, 29);

        // full rate: a word longer than the last bin, then a few one-letter words
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        send_word(70);
        send_req(CMD_CHAR, random_separator(), '0);
        for (int i = 0; i < 8; i++) begin
            send_req(CMD_CHAR, random_letter(), '0);
            send_req(CMD_CHAR, random_separator(), '0);
        end
        send_read(6'd1);
        send_read(LAST_BIN);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d bin reads), %0d words binned, four idle mixes",
                 sent_items, sent_reads, words_binned);
        $display("long words clamped into the last bin, same-bin words back to back");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
